[src/assert_macros.svh]
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked on the following clock edge
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

[src/mrc_pkg.sv]
// ----------------------------------------------------------------------------
// mrc_pkg
// shared constants and types of the reflection canonicalizer
// ----------------------------------------------------------------------------
`default_nettype none
package mrc_pkg;
    localparam int ENTRY_WIDTH_DEF = 16;
    localparam int FIBRE_WIDTH_DEF = 8;
    localparam int OUT_WIDTH       = 33;
    // candidate entries are carried at 64 bits, as the comparisons wrap there
    localparam int CW = 64;

    typedef logic signed [CW-1:0] t_ent;
    typedef t_ent t_mat [4];

    // comparison key of one candidate
    typedef struct packed {
        logic [CW-1:0] maxmag;
        logic [2:0]    zeros;
    } t_key;

    function automatic logic [CW-1:0] f_mag(input t_ent v);
        f_mag = v[CW-1] ? (CW'(0) - v) : v;
    endfunction
endpackage
`default_nettype wire

[src/matrix_reflection_canonicalizer.sv]
// ----------------------------------------------------------------------------
// matrix_reflection_canonicalizer
// picks the simplest reflection of a signed 2x2 matrix
// ----------------------------------------------------------------------------
// channel   direction  handshake
// command   in         i_start accepted when o_busy is low
// result    out        o_done strobe, one cycle, no back pressure
//
// one word accepted every cycle; o_busy is tied low
// pipeline: two product stages, normalization, compare, select
// synchronous active-low reset clears the valid bits only
// the receiver cannot stall, so no stage ever holds
`default_nettype none
module matrix_reflection_canonicalizer #(
    parameter int ENTRY_WIDTH = mrc_pkg::ENTRY_WIDTH_DEF,
    parameter int FIBRE_WIDTH = mrc_pkg::FIBRE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_in_a,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_in_b,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_in_c,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_in_d,
    input  wire logic [FIBRE_WIDTH-1:0]        i_fibres_first,
    input  wire logic [FIBRE_WIDTH-1:0]        i_fibres_second,
    output logic                               o_done,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_out_a,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_out_b,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_out_c,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_out_d,
    output logic                               o_reflect_first,
    output logic                               o_reflect_second
);
    import mrc_pkg::*;

    logic v2, v3;
    t_ent m [4], r0 [4], r1 [4], r01 [4];
    t_ent cand [4][4];
    t_ent ncand [4][4];
    t_key key [4];

    assign o_busy = 1'b0;

    mrc_prod #(.ENTRY_WIDTH(ENTRY_WIDTH), .FIBRE_WIDTH(FIBRE_WIDTH)) u_prod (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(i_start),
        .i_a(i_in_a), .i_b(i_in_b), .i_c(i_in_c), .i_d(i_in_d),
        .i_f0(i_fibres_first), .i_f1(i_fibres_second),
        .o_vld(v2), .o_m(m), .o_r0(r0), .o_r1(r1), .o_r01(r01)
    );

    assign cand[0] = m;
    assign cand[1] = r0;
    assign cand[2] = r1;
    assign cand[3] = r01;

    mrc_norm u_norm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v2), .i_c(cand),
        .o_vld(v3), .o_c(ncand), .o_k(key)
    );

    mrc_pick u_pick (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_vld(v3), .i_c(ncand), .i_k(key),
        .o_vld(o_done), .o_a(o_out_a), .o_b(o_out_b), .o_c(o_out_c),
        .o_d(o_out_d), .o_rf0(o_reflect_first), .o_rf1(o_reflect_second)
    );
endmodule
`default_nettype wire

[src/mrc_prod.sv]
// ----------------------------------------------------------------------------
// mrc_prod
// stages 1-2: forms the four candidates with registered products
// ----------------------------------------------------------------------------
`default_nettype none
module mrc_prod #(
    parameter int ENTRY_WIDTH = mrc_pkg::ENTRY_WIDTH_DEF,
    parameter int FIBRE_WIDTH = mrc_pkg::FIBRE_WIDTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_a,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_b,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_c,
    input  wire logic signed [ENTRY_WIDTH-1:0] i_d,
    input  wire logic [FIBRE_WIDTH-1:0]        i_f0,
    input  wire logic [FIBRE_WIDTH-1:0]        i_f1,
    output logic                               o_vld,
    output mrc_pkg::t_ent                      o_m   [4],
    output mrc_pkg::t_ent                      o_r0  [4],
    output mrc_pkg::t_ent                      o_r1  [4],
    output mrc_pkg::t_ent                      o_r01 [4]
);
    import mrc_pkg::*;

    // entry times fibre count, and that times the other fibre count
    localparam int PW = ENTRY_WIDTH + FIBRE_WIDTH + 1;
    localparam int QW = PW + FIBRE_WIDTH + 1;

    logic signed [FIBRE_WIDTH:0] f0_s, f1_s;
    logic r_v1;
    t_ent r_a, r_b, r_c, r_d;
    logic signed [FIBRE_WIDTH:0] r_f1;
    logic signed [PW-1:0] r_bf0, r_df0, r_f1a, r_f1b;
    logic r_v2;
    t_ent r_m [4];
    t_ent r_r0 [4];
    t_ent r_r1 [4];
    logic signed [QW-1:0] r_p0;
    t_ent r_p1;
    t_ent r_q [2];

    assign f0_s = {1'b0, i_f0};
    assign f1_s = {1'b0, i_f1};

    // stage 1: first products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_vld;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= CW'(i_a);
        r_b   <= CW'(i_b);
        r_c   <= CW'(i_c);
        r_d   <= CW'(i_d);
        r_f1  <= f1_s;
        r_bf0 <= i_b * f0_s;
        r_df0 <= i_d * f0_s;
        r_f1a <= i_a * f1_s;
        r_f1b <= i_b * f1_s;
    end

    // stage 2: sums and the products of the double reflection
    always_ff @(posedge i_clk) begin
        r_m[0] <= r_a; r_m[1] <= r_b; r_m[2] <= r_c; r_m[3] <= r_d;
        r_r0[0] <= r_a + CW'(r_bf0);
        r_r0[1] <= CW'(0) - r_b;
        r_r0[2] <= r_c + CW'(r_df0);
        r_r0[3] <= CW'(0) - r_d;
        r_r1[0] <= r_a;
        r_r1[1] <= r_b;
        r_r1[2] <= CW'(r_f1a) - r_c;
        r_r1[3] <= CW'(r_f1b) - r_d;
        // f1*(a+b*f0) = f1a + f1*b*f0, f1*(-b) = -f1b
        r_p0    <= r_f1 * r_bf0;
        r_p1    <= CW'(r_f1a);
        r_q[0]  <= r_c + CW'(r_df0);
        r_q[1]  <= CW'(r_f1b);
    end

    assign o_vld = r_v2;
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            o_m[i]  = r_m[i];
            o_r0[i] = r_r0[i];
            o_r1[i] = r_r1[i];
        end
        o_r01[0] = r_r0[0];
        o_r01[1] = r_r0[1];
        o_r01[2] = CW'(r_p0) + r_p1 - r_q[0];
        o_r01[3] = r_m[3] - r_q[1];
    end
endmodule
`default_nettype wire

[src/mrc_norm.sv]
// ----------------------------------------------------------------------------
// mrc_norm
// stage 3: sign normalization and comparison keys of the four candidates
// ----------------------------------------------------------------------------
`default_nettype none
module mrc_norm (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  mrc_pkg::t_ent i_c [4][4],
    output logic          o_vld,
    output mrc_pkg::t_ent o_c [4][4],
    output mrc_pkg::t_key o_k [4]
);
    import mrc_pkg::*;

    logic r_vld;
    t_ent n_c [4][4];
    t_key n_k [4];
    t_ent r_c [4][4];
    t_key r_k [4];

    // negate when the first nonzero entry is negative, then build keys
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            logic neg;
            neg = 1'b0;
            if (i_c[j][0] != 0) neg = i_c[j][0][CW-1];
            else if (i_c[j][1] != 0) neg = i_c[j][1][CW-1];
            else if (i_c[j][2] != 0) neg = i_c[j][2][CW-1];
            else neg = i_c[j][3][CW-1];
            n_k[j] = '0;
            for (int i = 0; i < 4; i++) begin
                n_c[j][i] = neg ? (CW'(0) - i_c[j][i]) : i_c[j][i];
                if (f_mag(i_c[j][i]) > n_k[j].maxmag) n_k[j].maxmag = f_mag(i_c[j][i]);
                if (i_c[j][i] == 0) n_k[j].zeros = n_k[j].zeros + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else r_vld <= i_vld;
    end

    always_ff @(posedge i_clk) begin
        r_c <= n_c;
        r_k <= n_k;
    end

    assign o_vld = r_vld;
    assign o_c   = r_c;
    assign o_k   = r_k;
endmodule
`default_nettype wire

[src/mrc_pick.sv]
// ----------------------------------------------------------------------------
// mrc_pick
// stages 4-5: pairwise simplicity order and choice of the result word
// ----------------------------------------------------------------------------
`default_nettype none
module mrc_pick (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_vld,
    input  mrc_pkg::t_ent i_c [4][4],
    input  mrc_pkg::t_key i_k [4],
    output logic          o_vld,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_a,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_b,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_c,
    output logic signed [mrc_pkg::OUT_WIDTH-1:0] o_d,
    output logic          o_rf0,
    output logic          o_rf1
);
    import mrc_pkg::*;
    `include "assert_macros.svh"

    // candidate order: 0 = m, 1 = r0, 2 = r1, 3 = r01
    localparam int NP = 6;
    // pairs compared: r0<m, r0<r1, r0<r01, r1<m, r1<r01, r01<m
    localparam logic [1:0] PX [NP] = '{2'd1, 2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
    localparam logic [1:0] PY [NP] = '{2'd0, 2'd2, 2'd3, 2'd0, 2'd3, 2'd0};

    logic r_v4, r_v5;
    logic [NP-1:0] n_s, r_s;
    t_ent r_c [4][4];
    logic [1:0] n_sel;
    logic signed [OUT_WIDTH-1:0] r_o [4];
    logic r_f0, r_f1;

    function automatic logic f_simpler(input t_key kx, input t_key ky,
                                       input t_ent x [4], input t_ent y [4]);
        logic res, done;
        res = 1'b0;
        done = 1'b0;
        if (kx.maxmag != ky.maxmag) begin
            res = kx.maxmag < ky.maxmag;
        end else if (kx.zeros != ky.zeros) begin
            res = kx.zeros > ky.zeros;
        end else begin
            for (int i = 0; i < 4; i++) begin
                if (!done && x[i] != y[i]) begin
                    res = x[i] < y[i];
                    done = 1'b1;
                end
            end
        end
        f_simpler = res;
    endfunction

    // stage 4: six comparisons
    always_comb begin
        for (int p = 0; p < NP; p++)
            n_s[p] = f_simpler(i_k[PX[p]], i_k[PY[p]], i_c[PX[p]], i_c[PY[p]]);
    end

    always_ff @(posedge i_clk) begin
        r_s <= n_s;
        r_c <= i_c;
    end

    // stage 5: priority choice
    always_comb begin
        priority if (r_s[0] && r_s[1] && r_s[2]) n_sel = 2'd1;
        else if (r_s[3] && r_s[4])                n_sel = 2'd2;
        else if (r_s[5])                          n_sel = 2'd3;
        else                                      n_sel = 2'd0;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) r_o[i] <= r_c[n_sel][i][OUT_WIDTH-1:0];
        r_f0 <= n_sel[0];
        r_f1 <= n_sel[1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            r_v4 <= i_vld;
            r_v5 <= r_v4;
        end
    end

    assign o_vld = r_v5;
    assign o_a = r_o[0];
    assign o_b = r_o[1];
    assign o_c = r_o[2];
    assign o_d = r_o[3];
    assign o_rf0 = r_f0;
    assign o_rf1 = r_f1;

    // valid bits travel with the word, flags agree with the comparisons
    `ASSERT_NEXT(a_valid_chain, i_clk, i_rst_n, i_vld, r_v4)
    `ASSERT_IMP(a_pick_r0, i_clk, i_rst_n, r_v5 && r_f0 && !r_f1,
                $past(r_s[0] && r_s[1] && r_s[2]))
    `ASSERT_IMP(a_pick_r1, i_clk, i_rst_n, r_v5 && !r_f0 && r_f1,
                $past(r_s[3] && r_s[4]))
    `ASSERT_IMP(a_pick_r01, i_clk, i_rst_n, r_v5 && r_f0 && r_f1, $past(r_s[5]))
endmodule
`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// checks the reflection canonicalizer against a built-in predictor: directed
// corner matrices, then random words under several sender idling phases
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int EW       = mrc_pkg::ENTRY_WIDTH_DEF;
    localparam int FW       = mrc_pkg::FIBRE_WIDTH_DEF;
    localparam int OW       = mrc_pkg::OUT_WIDTH;
    localparam int N_RANDOM = 1700;
    localparam int WDOG_MAX = 2000;
    localparam int DRAIN    = 20;

    typedef logic signed [63:0] t_w;

    typedef struct packed {
        logic signed [EW-1:0] a, b, c, d;
        logic [FW-1:0]        f0, f1;
    } t_word;

    typedef struct packed {
        logic signed [OW-1:0] a, b, c, d;
        logic                 rf0, rf1;
    } t_canon;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic signed [EW-1:0] in_a, in_b, in_c, in_d;
    logic [FW-1:0]        fib0, fib1;
    logic                 done;
    logic signed [OW-1:0] out_a, out_b, out_c, out_d;
    logic                 refl0, refl1;

    t_word  pending_words[$];
    t_canon expected_canon[$];
    int     n_errors = 0;
    int     n_checked = 0;
    int     idle_pct = 0;
    int     wdog = 0;

    matrix_reflection_canonicalizer DUT (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_in_a(in_a), .i_in_b(in_b), .i_in_c(in_c), .i_in_d(in_d),
        .i_fibres_first(fib0), .i_fibres_second(fib1),
        .o_done(done), .o_out_a(out_a), .o_out_b(out_b), .o_out_c(out_c),
        .o_out_d(out_d), .o_reflect_first(refl0), .o_reflect_second(refl1)
    );

    always #2 clk = ~clk;

    // flip sign so the first nonzero entry is positive
    function automatic void normalize_sign(ref t_w m[4]);
        for (int i = 0; i < 4; i++) begin
            if (m[i] != 0) begin
                if (m[i] < 0) begin
                    for (int k = 0; k < 4; k++) m[k] = -m[k];
                end
                return;
            end
        end
    endfunction

    // max magnitude, then zero count, then signed row-major order
    function automatic bit simpler_than(t_w x[4], t_w y[4]);
        logic [63:0] mx, my, ax, ay;
        int zx, zy;
        mx = 0; my = 0; zx = 0; zy = 0;
        for (int i = 0; i < 4; i++) begin
            ax = x[i][63] ? -x[i] : x[i];
            ay = y[i][63] ? -y[i] : y[i];
            if (ax > mx) mx = ax;
            if (ay > my) my = ay;
            if (x[i] == 0) zx++;
            if (y[i] == 0) zy++;
        end
        if (mx != my) return mx < my;
        if (zx != zy) return zx > zy;
        for (int i = 0; i < 4; i++) begin
            if (x[i] < y[i]) return 1;
            if (x[i] > y[i]) return 0;
        end
        return 0;
    endfunction

    function automatic t_canon canonical_form(t_word w);
        t_w m[4], r0[4], r1[4], r01[4], p[4];
        t_w f0, f1;
        t_canon res;
        f0 = t_w'(w.f0);
        f1 = t_w'(w.f1);
        m[0] = w.a; m[1] = w.b; m[2] = w.c; m[3] = w.d;
        r0[0] = m[0] + m[1] * f0; r0[1] = -m[1];
        r0[2] = m[2] + m[3] * f0; r0[3] = -m[3];
        r1[0] = m[0]; r1[1] = m[1];
        r1[2] = f1 * m[0] - m[2]; r1[3] = f1 * m[1] - m[3];
        r01[0] = r0[0]; r01[1] = r0[1];
        r01[2] = f1 * r0[0] - r0[2]; r01[3] = f1 * r0[1] - r0[3];
        normalize_sign(m); normalize_sign(r0);
        normalize_sign(r1); normalize_sign(r01);
        if (simpler_than(r0, m) && simpler_than(r0, r1) && simpler_than(r0, r01)) begin
            p = r0; res.rf0 = 1; res.rf1 = 0;
        end else if (simpler_than(r1, m) && simpler_than(r1, r01)) begin
            p = r1; res.rf0 = 0; res.rf1 = 1;
        end else if (simpler_than(r01, m)) begin
            p = r01; res.rf0 = 1; res.rf1 = 1;
        end else begin
            p = m; res.rf0 = 0; res.rf1 = 0;
        end
        res.a = p[0][OW-1:0]; res.b = p[1][OW-1:0];
        res.c = p[2][OW-1:0]; res.d = p[3][OW-1:0];
        return res;
    endfunction

    function automatic logic [EW-1:0] rand_entry();
        case ($urandom_range(0, 5))
            0: return EW'($urandom);
            1: return EW'($signed($urandom_range(0, 6)) - 3);
            2: return {1'b1, {(EW-1){1'b0}}};
            3: return {1'b0, {(EW-1){1'b1}}};
            default: return EW'($signed($urandom_range(0, 40)) - 20);
        endcase
    endfunction

    function automatic logic [FW-1:0] rand_fibre();
        case ($urandom_range(0, 3))
            0: return FW'($urandom);
            1: return {FW{1'b1}};
            default: return FW'($urandom_range(0, 4));
        endcase
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        n_errors++;
        $display("mismatch on %s: got %0d expected %0d at %0t", field, got, want, $time);
    endtask

    // driver: present a word at the falling edge, keep it until accepted
    always @(negedge clk) begin
        if (!rst_n) begin
            start <= 1'b0;
        end else if (!(start && busy)) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
                t_word w;
                w = pending_words.pop_front();
                start <= 1'b1;
                in_a <= w.a; in_b <= w.b; in_c <= w.c; in_d <= w.d;
                fib0 <= w.f0; fib1 <= w.f1;
                expected_canon.push_back(canonical_form(w));
            end else begin
                start <= 1'b0;
            end
        end
    end

    // monitor: compare each strobed result with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && done) begin
            if (expected_canon.size() == 0) begin
                report_mismatch("unexpected word", 0, 0);
            end else begin
                t_canon e;
                e = expected_canon.pop_front();
                n_checked++;
                if (out_a !== e.a) report_mismatch("out_a", out_a, e.a);
                if (out_b !== e.b) report_mismatch("out_b", out_b, e.b);
                if (out_c !== e.c) report_mismatch("out_c", out_c, e.c);
                if (out_d !== e.d) report_mismatch("out_d", out_d, e.d);
                if (refl0 !== e.rf0) report_mismatch("reflect_first", refl0, e.rf0);
                if (refl1 !== e.rf1) report_mismatch("reflect_second", refl1, e.rf1);
            end
        end
    end

    // watchdog on cycles without any accepted word or strobed result
    always @(posedge clk) begin
        if ((start && !busy) || done) wdog <= 0;
        else wdog <= wdog + 1;
        if (wdog >= WDOG_MAX) begin
            $display("watchdog expired with %0d results outstanding", expected_canon.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic push_word(int a, int b, int c, int d, int f0, int f1);
        t_word w;
        w.a = EW'(a); w.b = EW'(b); w.c = EW'(c); w.d = EW'(d);
        w.f0 = FW'(f0); w.f1 = FW'(f1);
        pending_words.push_back(w);
    endtask

    task automatic wait_drained();
        wait (pending_words.size() == 0 && expected_canon.size() == 0);
    endtask

    initial begin
        int fmax;
        int emin;
        int emax;
        fmax = (1 << FW) - 1;
        emin = -(1 << (EW - 1));
        emax = (1 << (EW - 1)) - 1;
        rst_n = 1'b0; start = 1'b0;
        in_a = '0; in_b = '0; in_c = '0; in_d = '0; fib0 = '0; fib1 = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed corners: zero matrix, extremes, sign cases, fibre extremes
        push_word(0, 0, 0, 0, 0, 0);
        push_word(0, 0, 0, 0, fmax, fmax);
        push_word(1, 0, 0, 1, 0, 0);
        push_word(-1, 0, 0, -1, 1, 1);
        push_word(0, -3, 2, 1, 2, 3);
        push_word(0, 0, 0, -5, 1, 0);
        push_word(emin, emin, emin, emin, fmax, fmax);
        push_word(emax, emax, emax, emax, fmax, fmax);
        push_word(emin, emax, emax, emin, fmax, 0);
        push_word(emax, emin, emin, emax, 0, fmax);
        push_word(1, -1, 2, -1, 2, 2);
        push_word(3, -1, 5, -2, 3, 2);
        push_word(2, 1, 1, 1, 1, 1);
        push_word(-1, 1, 0, 0, 2, 0);
        push_word(5, 2, 3, 1, 2, 3);
        push_word(0, 1, 1, 0, 0, 0);
        push_word(7, -3, -3, 2, fmax, 1);
        push_word(-2, 2, -2, 2, 2, 2);
        wait_drained();

        // random phases with different sender idling
        for (int ph = 0; ph < 4; ph++) begin
            idle_pct = (ph == 1) ? 67 : (ph == 3) ? 25 : 0;
            for (int i = 0; i < N_RANDOM / 4; i++) begin
                t_word w;
                w.a = rand_entry(); w.b = rand_entry();
                w.c = rand_entry(); w.d = rand_entry();
                w.f0 = rand_fibre(); w.f1 = rand_fibre();
                pending_words.push_back(w);
            end
            wait_drained();
        end
        repeat (DRAIN) @(posedge clk);

        $display("checked %0d result words over directed corners and four idling phases",
                 n_checked);
        if (n_errors == 0 && expected_canon.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
